@@ src/hmp_pkg.sv @@
// Package for the HID macro player: operation and action codes, tap kinds,
// configuration register indexes and the key and mouse bit decoders.
// Depends on nothing; used by hid_macro_player.
package hmp_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [7:0] ACT_PRESS     = 8'd1;
    localparam logic [7:0] ACT_RELEASE   = 8'd2;
    localparam logic [7:0] ACT_KEY_TAP   = 8'd3;
    localparam logic [7:0] ACT_DELAY     = 8'd4;
    localparam logic [7:0] ACT_MEDIA_TAP = 8'd5;
    localparam logic [7:0] ACT_MOUSE_TAP = 8'd6;

    localparam logic [2:0] TAP_NONE  = 3'd0;
    localparam logic [2:0] TAP_KEY   = 3'd3;
    localparam logic [2:0] TAP_MEDIA = 3'd5;
    localparam logic [2:0] TAP_MOUSE = 3'd6;

    localparam logic [1:0] CFG_ACTION_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOOP_MODE    = 2'd1;
    localparam logic [1:0] CFG_TICK_MS      = 2'd2;

    localparam logic [7:0] TICK_MS_RESET = 8'd10;
    localparam logic [7:0] MOD_FIRST     = 8'hE0;
    localparam logic [7:0] MOD_LAST      = 8'hE7;
    localparam logic [7:0] USAGE_LAST    = 8'h77;
    localparam logic [7:0] MEDIA_CODES   = 8'd32;
    localparam logic [7:0] MOUSE_WHEEL   = 8'd3;

    typedef struct packed {
        logic       hit;
        logic [6:0] pos;
    } t_key_pos;

    function automatic t_key_pos key_decode(input logic [7:0] usage);
        t_key_pos kp;
        kp.hit = 1'b0;
        kp.pos = '0;
        if (usage >= MOD_FIRST && usage <= MOD_LAST) begin
            kp.hit = 1'b1;
            kp.pos = 7'(usage[2:0]);
        end else if (usage <= USAGE_LAST) begin
            kp.hit = 1'b1;
            kp.pos = usage[6:0] + 7'd8;
        end
        return kp;
    endfunction

    function automatic logic [31:0] mouse_mask(input logic [7:0] code);
        logic [31:0] m;
        if (code < MOUSE_WHEEL) begin
            m = 32'd1 << code[1:0];
        end else if (code == MOUSE_WHEEL) begin
            m = 32'h0100_0000;
        end else begin
            m = 32'hFF00_0000;
        end
        return m;
    endfunction

endpackage

@@ src/hid_macro_player.sv @@
// HID macro player top level: action table memory, playback sequencer and
// the registered result stage.
// Depends on hmp_pkg.
//
// Usage: each input transaction is either a table write or a tick. Every
// input transaction yields exactly one output transaction that shows the
// keyboard, media and mouse bitmaps and the player status after it.
// Configuration registers are to be written through the plain write port
// while the block is idle; the block itself does not enforce this.
// Sequencing: a write goes from idle to the publish state, which loads its
// result into the output register. A tick passes through the advance state,
// then one exec state per table action executed (at most TABLE_DEPTH), then
// publish. The action table is a synchronous memory read at one entry per
// cycle.
// Throughput: one transaction at a time; input is taken again the cycle
// after a result is loaded, even if the receiver has not yet taken it.
// Stalls: while the receiver holds ready low, a finished result waits in
// the output register and the following transaction waits before it is
// published.
// Reset: synchronous, active low. The player stops, all bitmaps clear and
// the registers return to count 0, loop off and a 10 ms tick. The table
// contents are not cleared.
module hid_macro_player #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [5:0]  i_entry_index,
    input  logic [7:0]  i_action_type,
    input  logic [7:0]  i_action_value,
    input  logic [15:0] i_action_param,
    input  logic        i_start_request,
    input  logic [7:0]  i_macro_id,
    input  logic        i_source_held,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_keys_low,
    output logic [63:0] o_keys_high,
    output logic [31:0] o_media_bits,
    output logic [31:0] o_mouse_bits,
    output logic        o_running,
    output logic [6:0]  o_play_index,
    output logic [15:0] o_delay_left,
    output logic        o_tap_pending
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int STEP_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_DEPTH - 1);
    localparam logic [6:0] DEPTH_CAP = (TABLE_DEPTH > 127) ? 7'd127 : 7'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADVANCE,
        S_EXEC,
        S_PUBLISH
    } t_state;

    t_state r_state, n_state;

    logic [6:0]  r_action_count;
    logic        r_loop_mode;
    logic [7:0]  r_tick_ms;

    logic [127:0] r_keys, n_keys;
    logic [31:0]  r_media, n_media;
    logic [31:0]  r_mouse, n_mouse;
    logic         r_playing, n_playing;
    logic [6:0]   r_next, n_next;
    logic [15:0]  r_delay, n_delay;
    logic         r_tap_active, n_tap_active;
    logic [2:0]   r_tap_kind, n_tap_kind;
    logic [7:0]   r_tap_code, n_tap_code;
    logic         r_held, n_held;
    logic [STEP_W-1:0] r_step, n_step;

    logic [31:0]  r_table [TABLE_DEPTH];
    logic [31:0]  r_rd_data;
    logic         mem_we;
    logic [AW-1:0] mem_wr_addr;
    logic         mem_rd_en;
    logic [AW-1:0] mem_rd_addr;

    logic         r_out_valid;
    logic [127:0] r_out_keys;
    logic [31:0]  r_out_media;
    logic [31:0]  r_out_mouse;
    logic         r_out_running;
    logic [6:0]   r_out_index;
    logic [15:0]  r_out_delay;
    logic         r_out_tap;
    logic         out_load;

    logic [6:0]  eff_count;
    logic [7:0]  tick_len;
    logic        wrap_ok;
    logic [6:0]  exec_next;
    logic [7:0]  exec_type;
    logic [7:0]  exec_val;
    logic [15:0] exec_param;
    hmp_pkg::t_key_pos exec_key;
    hmp_pkg::t_key_pos tap_key;
    logic [127:0] exec_key_mask;
    logic [127:0] tap_key_mask;
    logic        exec_wait;

    assign eff_count = (r_action_count > DEPTH_CAP) ? DEPTH_CAP : r_action_count;
    assign tick_len  = (r_tick_ms == 8'd0) ? 8'd1 : r_tick_ms;
    assign wrap_ok   = r_loop_mode && r_held;
    assign o_in_ready = (r_state == S_IDLE);

    assign exec_next  = r_next + 7'd1;
    assign exec_type  = r_rd_data[7:0];
    assign exec_val   = r_rd_data[15:8];
    assign exec_param = r_rd_data[31:16];
    assign exec_key   = hmp_pkg::key_decode(exec_val);
    assign tap_key    = hmp_pkg::key_decode(r_tap_code);
    assign exec_key_mask = 128'd1 << exec_key.pos;
    assign tap_key_mask  = 128'd1 << tap_key.pos;
    assign mem_wr_addr   = AW'(i_entry_index);

    always_comb begin
        n_state      = r_state;
        n_keys       = r_keys;
        n_media      = r_media;
        n_mouse      = r_mouse;
        n_playing    = r_playing;
        n_next       = r_next;
        n_delay      = r_delay;
        n_tap_active = r_tap_active;
        n_tap_kind   = r_tap_kind;
        n_tap_code   = r_tap_code;
        n_held       = r_held;
        n_step       = r_step;
        mem_we       = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = '0;
        out_load     = 1'b0;
        exec_wait    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == hmp_pkg::OP_WRITE) begin
                        mem_we  = !r_playing && (32'(i_entry_index) < TABLE_DEPTH);
                        n_state = S_PUBLISH;
                    end else begin
                        n_held = i_source_held;
                        if (i_start_request && !r_playing && i_macro_id != 8'd0
                                && eff_count != 7'd0) begin
                            n_keys       = '0;
                            n_media      = '0;
                            n_mouse      = '0;
                            n_tap_active = 1'b0;
                            n_tap_kind   = hmp_pkg::TAP_NONE;
                            n_tap_code   = '0;
                            n_playing    = 1'b1;
                            n_next       = '0;
                            n_delay      = '0;
                            n_held       = 1'b1;
                        end
                        n_state = S_ADVANCE;
                    end
                end
            end

            S_ADVANCE: begin
                n_state = S_PUBLISH;
                if (!r_playing) begin
                    n_state = S_PUBLISH;
                end else if (r_tap_active) begin
                    if (r_tap_kind == hmp_pkg::TAP_KEY) begin
                        if (tap_key.hit) begin
                            n_keys = r_keys & ~tap_key_mask;
                        end
                    end else if (r_tap_kind == hmp_pkg::TAP_MEDIA
                                 && r_tap_code < hmp_pkg::MEDIA_CODES) begin
                        n_media = r_media & ~(32'd1 << r_tap_code[4:0]);
                    end else if (r_tap_kind == hmp_pkg::TAP_MOUSE) begin
                        n_mouse = r_mouse & ~hmp_pkg::mouse_mask(r_tap_code);
                    end
                    n_tap_active = 1'b0;
                    n_tap_kind   = hmp_pkg::TAP_NONE;
                    n_tap_code   = '0;
                end else if (r_delay != 16'd0) begin
                    n_delay = (r_delay > 16'(tick_len)) ? r_delay - 16'(tick_len) : 16'd0;
                end else if (r_next >= eff_count && !wrap_ok) begin
                    n_playing    = 1'b0;
                    n_next       = '0;
                    n_delay      = '0;
                    n_keys       = '0;
                    n_media      = '0;
                    n_mouse      = '0;
                    n_tap_active = 1'b0;
                    n_tap_kind   = hmp_pkg::TAP_NONE;
                    n_tap_code   = '0;
                end else begin
                    if (r_next >= eff_count) begin
                        n_keys       = '0;
                        n_media      = '0;
                        n_mouse      = '0;
                        n_tap_active = 1'b0;
                        n_tap_kind   = hmp_pkg::TAP_NONE;
                        n_tap_code   = '0;
                        n_next       = '0;
                    end
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(n_next);
                    n_step      = '0;
                    n_state     = S_EXEC;
                end
            end

            S_EXEC: begin
                n_next = exec_next;
                if (exec_type == hmp_pkg::ACT_PRESS) begin
                    if (exec_key.hit) begin
                        n_keys = r_keys | exec_key_mask;
                    end
                end else if (exec_type == hmp_pkg::ACT_RELEASE) begin
                    if (exec_key.hit) begin
                        n_keys = r_keys & ~exec_key_mask;
                    end
                end else if (exec_type == hmp_pkg::ACT_KEY_TAP) begin
                    if (exec_key.hit) begin
                        n_keys = r_keys | exec_key_mask;
                    end
                    n_tap_active = 1'b1;
                    n_tap_kind   = hmp_pkg::TAP_KEY;
                    n_tap_code   = exec_val;
                    exec_wait    = 1'b1;
                end else if (exec_type == hmp_pkg::ACT_DELAY) begin
                    n_delay   = exec_param;
                    exec_wait = 1'b1;
                end else if (exec_type == hmp_pkg::ACT_MEDIA_TAP) begin
                    if (exec_val < hmp_pkg::MEDIA_CODES) begin
                        n_media      = r_media | (32'd1 << exec_val[4:0]);
                        n_tap_active = 1'b1;
                        n_tap_kind   = hmp_pkg::TAP_MEDIA;
                        n_tap_code   = exec_val;
                        exec_wait    = 1'b1;
                    end
                end else if (exec_type == hmp_pkg::ACT_MOUSE_TAP) begin
                    n_mouse      = r_mouse | hmp_pkg::mouse_mask(exec_val);
                    n_tap_active = 1'b1;
                    n_tap_kind   = hmp_pkg::TAP_MOUSE;
                    n_tap_code   = exec_val;
                    exec_wait    = 1'b1;
                end

                if (exec_wait || r_step == LAST_STEP) begin
                    n_state = S_PUBLISH;
                end else if (exec_next >= eff_count && !wrap_ok) begin
                    n_playing    = 1'b0;
                    n_next       = '0;
                    n_delay      = '0;
                    n_keys       = '0;
                    n_media      = '0;
                    n_mouse      = '0;
                    n_tap_active = 1'b0;
                    n_tap_kind   = hmp_pkg::TAP_NONE;
                    n_tap_code   = '0;
                    n_state      = S_PUBLISH;
                end else begin
                    if (exec_next >= eff_count) begin
                        n_keys       = '0;
                        n_media      = '0;
                        n_mouse      = '0;
                        n_tap_active = 1'b0;
                        n_tap_kind   = hmp_pkg::TAP_NONE;
                        n_tap_code   = '0;
                        n_next       = '0;
                    end
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(n_next);
                    n_step      = r_step + STEP_W'(1);
                end
            end

            S_PUBLISH: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_wr_addr] <= {i_action_param, i_action_value, i_action_type};
        end
        if (mem_rd_en) begin
            r_rd_data <= r_table[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_action_count <= '0;
            r_loop_mode    <= 1'b0;
            r_tick_ms      <= hmp_pkg::TICK_MS_RESET;
            r_keys         <= '0;
            r_media        <= '0;
            r_mouse        <= '0;
            r_playing      <= 1'b0;
            r_next         <= '0;
            r_delay        <= '0;
            r_tap_active   <= 1'b0;
            r_tap_kind     <= hmp_pkg::TAP_NONE;
            r_tap_code     <= '0;
            r_held         <= 1'b0;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_keys       <= n_keys;
            r_media      <= n_media;
            r_mouse      <= n_mouse;
            r_playing    <= n_playing;
            r_next       <= n_next;
            r_delay      <= n_delay;
            r_tap_active <= n_tap_active;
            r_tap_kind   <= n_tap_kind;
            r_tap_code   <= n_tap_code;
            r_held       <= n_held;
            r_step       <= n_step;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hmp_pkg::CFG_ACTION_COUNT: r_action_count <= i_cfg_data[6:0];
                    hmp_pkg::CFG_LOOP_MODE:    r_loop_mode    <= i_cfg_data[0];
                    hmp_pkg::CFG_TICK_MS:      r_tick_ms      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_keys    <= r_keys;
            r_out_media   <= r_media;
            r_out_mouse   <= r_mouse;
            r_out_running <= r_playing;
            r_out_index   <= (r_next > eff_count) ? eff_count : r_next;
            r_out_delay   <= r_delay;
            r_out_tap     <= r_tap_active;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_keys_low    = r_out_keys[63:0];
    assign o_keys_high   = r_out_keys[127:64];
    assign o_media_bits  = r_out_media;
    assign o_mouse_bits  = r_out_mouse;
    assign o_running     = r_out_running;
    assign o_play_index  = r_out_index;
    assign o_delay_left  = r_out_delay;
    assign o_tap_pending = r_out_tap;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_step <= LAST_STEP))
        else $error("action step counter ran past the table depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (32'(r_next) < TABLE_DEPTH))
        else $error("table read outside the table");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_playing)
            |-> (!r_tap_active && r_delay == 16'd0 && r_next == 7'd0))
        else $error("stopped player holds stale playback state");

    a_publish_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_PUBLISH))
        else $error("result published outside the publish state");

endmodule
